### hw/rtl/aps_pkg.sv
// Shared types and constants for the actuator position sequencer.
// No dependencies; the top level and aps_seq refer to this package.
`timescale 1ns / 1ps

package aps_pkg;

	// Command mode codes carried on the input channel
	localparam logic [1:0] MODE_TICK    = 2'd0;
	localparam logic [1:0] MODE_WORK    = 2'd1;
	localparam logic [1:0] MODE_SERVICE = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_WEIGHT_FITTED  = 2'd0;
	localparam logic [1:0] CFG_SETTLE_TICKS   = 2'd1;
	localparam logic [1:0] CFG_MODULE_TIMEOUT = 2'd2;
	localparam logic [1:0] CFG_WEIGHT_TIMEOUT = 2'd3;

	// Configuration reset values
	localparam logic [15:0] SETTLE_TICKS_RST   = 16'd500;
	localparam logic [15:0] MODULE_TIMEOUT_RST = 16'd10000;
	localparam logic [15:0] WEIGHT_TIMEOUT_RST = 16'd5000;

	// Pending step mask bits
	localparam logic [2:0] STEP_RETRACT = 3'b001;
	localparam logic [2:0] STEP_MOVE    = 3'b010;
	localparam logic [2:0] STEP_ENGAGE  = 3'b100;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SETTLE,
		PH_WAIT
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK              = 3'd0,
		ST_MODULE_TIMEOUT  = 3'd1,
		ST_RETRACT_TIMEOUT = 3'd2,
		ST_ENGAGE_TIMEOUT  = 3'd3,
		ST_SWITCH_FAULT    = 3'd4,
		ST_POS_UNKNOWN     = 3'd5
	} status_t;

	// Outcome of classifying a switch code
	typedef enum logic [1:0] {
		CL_STEPS,
		CL_OK,
		CL_FAULT,
		CL_SETTLE
	} class_kind_t;

	typedef struct packed {
		logic        weight_fitted;
		logic [15:0] settle_ticks;
		logic [15:0] module_timeout;
		logic [15:0] weight_timeout;
	} cfg_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       at_work;
		logic       at_service;
		logic       weight_home;
	} cmd_t;

	typedef struct packed {
		logic       pulse_to_work;
		logic       pulse_to_service;
		logic       pulse_weight_retract;
		logic       pulse_weight_engage;
		logic       busy_res;
		logic       done_res;
		logic [2:0] status;
	} res_t;

endpackage

### hw/rtl/aps_cmd_if.sv
// Input channel of the sequencer: ticks and commands with switch samples.
// Depends on nothing.
`timescale 1ns / 1ps

interface aps_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic       at_work;
	logic       at_service;
	logic       weight_home;

	modport source (output valid, mode, at_work, at_service, weight_home, input ready);
	modport sink   (input valid, mode, at_work, at_service, weight_home, output ready);
endinterface

### hw/rtl/aps_res_if.sv
// Result channel of the sequencer: pulses, busy, done and status.
// Depends on nothing.
`timescale 1ns / 1ps

interface aps_res_if;
	logic       valid;
	logic       ready;
	logic       pulse_to_work;
	logic       pulse_to_service;
	logic       pulse_weight_retract;
	logic       pulse_weight_engage;
	logic       busy_res;
	logic       done_res;
	logic [2:0] status;

	modport source (output valid, pulse_to_work, pulse_to_service, pulse_weight_retract,
		pulse_weight_engage, busy_res, done_res, status, input ready);
	modport sink   (input valid, pulse_to_work, pulse_to_service, pulse_weight_retract,
		pulse_weight_engage, busy_res, done_res, status, output ready);
endinterface

### hw/rtl/aps_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on nothing.
`timescale 1ns / 1ps

interface aps_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/actuator_position_sequencer.sv
// Top level of the actuator position sequencer: config registers and result register.
// Depends on aps_pkg, aps_cmd_if, aps_res_if, aps_cfg_if and aps_seq.
`timescale 1ns / 1ps

//  channel | dir | payload                                        | accepted when
//  cmd     | in  | mode, at_work, at_service, weight_home         | valid && ready
//  res     | out | four pulses, busy_res, done_res, status        | valid && ready
//  cfg     | in  | index (2b), data (16b)                         | valid && ready
//
// One item per cycle while res is not stalled: the state update and the result
// are registered on accept, and the result register holds it until the sink takes it.
// cmd.ready stays high while the result register is empty or being drained
// in the same cycle; a stall on res holds back cmd only.
// cfg.ready is always high. arst_n clears state and loads register defaults.

module actuator_position_sequencer #(
	parameter int MAX_TRIES = 3
) (
	input logic         clk,
	input logic         arst_n,
	aps_cmd_if.sink     cmd,
	aps_res_if.source   res,
	aps_cfg_if.sink     cfg
);

	aps_pkg::cfg_t cfg_q;
	aps_pkg::cmd_t cmd_in;
	aps_pkg::res_t res_n;
	aps_pkg::res_t res_q;
	logic          res_valid_q;
	logic          take;

	assign cfg.ready = 1'b1;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.weight_fitted  <= 1'b0;
			cfg_q.settle_ticks   <= aps_pkg::SETTLE_TICKS_RST;
			cfg_q.module_timeout <= aps_pkg::MODULE_TIMEOUT_RST;
			cfg_q.weight_timeout <= aps_pkg::WEIGHT_TIMEOUT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				aps_pkg::CFG_WEIGHT_FITTED:  cfg_q.weight_fitted  <= cfg.data[0];
				aps_pkg::CFG_SETTLE_TICKS:   cfg_q.settle_ticks   <= cfg.data;
				aps_pkg::CFG_MODULE_TIMEOUT: cfg_q.module_timeout <= cfg.data;
				default:                     cfg_q.weight_timeout <= cfg.data;
			endcase
		end
	end

	// Accept a transaction whenever the result slot frees up
	assign cmd.ready = !res_valid_q || res.ready;
	assign take      = cmd.valid && cmd.ready;

	assign cmd_in.mode        = cmd.mode;
	assign cmd_in.at_work     = cmd.at_work;
	assign cmd_in.at_service  = cmd.at_service;
	assign cmd_in.weight_home = cmd.weight_home;

	aps_seq #(
		.MAX_TRIES (MAX_TRIES)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.cmd_in (cmd_in),
		.cfg    (cfg_q),
		.res_n  (res_n)
	);

	// Result valid: set on accept, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_n;
		end
	end

	assign res.valid                = res_valid_q;
	assign res.pulse_to_work        = res_q.pulse_to_work;
	assign res.pulse_to_service     = res_q.pulse_to_service;
	assign res.pulse_weight_retract = res_q.pulse_weight_retract;
	assign res.pulse_weight_engage  = res_q.pulse_weight_engage;
	assign res.busy_res             = res_q.busy_res;
	assign res.done_res             = res_q.done_res;
	assign res.status               = res_q.status;

endmodule

### hw/rtl/aps_seq.sv
// Sequencer state and per-item next-state logic.
// Depends on aps_pkg for the config, command and result types.
`timescale 1ns / 1ps

module aps_seq #(
	parameter int MAX_TRIES = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  aps_pkg::cmd_t cmd_in,
	input  aps_pkg::cfg_t cfg,
	output aps_pkg::res_t res_n
);

	localparam logic [1:0] TRIES_LIMIT = 2'(MAX_TRIES);

	aps_pkg::phase_t phase_q, phase_n;
	logic            target_q, target_n;
	logic [2:0]      pending_q, pending_n;
	logic [15:0]     timer_q, timer_n;
	logic [1:0]      tries_q, tries_n;

	// Classify a switch code into the step mask or an immediate outcome
	function automatic void classify(input logic wf, input logic tgt, input logic [2:0] code,
		output aps_pkg::class_kind_t kind, output logic [2:0] steps);
		kind  = aps_pkg::CL_STEPS;
		steps = 3'b000;
		if (!wf) begin
			case (code[1:0])
				2'd0: kind = aps_pkg::CL_SETTLE;
				2'd3: kind = aps_pkg::CL_FAULT;
				2'd1: if (tgt) steps = aps_pkg::STEP_MOVE; else kind = aps_pkg::CL_OK;
				default: if (tgt) kind = aps_pkg::CL_OK; else steps = aps_pkg::STEP_MOVE;
			endcase
		end else begin
			case (code)
				3'd0, 3'd4: kind = aps_pkg::CL_SETTLE;
				3'd3, 3'd7: kind = aps_pkg::CL_FAULT;
				3'd1: begin
					if (tgt) steps = aps_pkg::STEP_RETRACT | aps_pkg::STEP_MOVE;
					else kind = aps_pkg::CL_OK;
				end
				3'd2: begin
					if (tgt) steps = aps_pkg::STEP_RETRACT;
					else steps = aps_pkg::STEP_RETRACT | aps_pkg::STEP_MOVE
						| aps_pkg::STEP_ENGAGE;
				end
				3'd5: steps = tgt ? aps_pkg::STEP_MOVE : aps_pkg::STEP_ENGAGE;
				default: begin
					if (tgt) kind = aps_pkg::CL_OK;
					else steps = aps_pkg::STEP_MOVE | aps_pkg::STEP_ENGAGE;
				end
			endcase
		end
	endfunction

	// Next state and result for the item on the input
	always_comb begin
		logic [2:0]            code;
		logic                  do_eval;
		logic                  do_begin;
		logic                  do_finish;
		aps_pkg::status_t      fin_status;
		aps_pkg::class_kind_t  kind;
		logic [2:0]            steps;
		logic [2:0]            cur;
		logic                  reached;
		aps_pkg::status_t      err;

		code       = {cmd_in.weight_home, cmd_in.at_service, cmd_in.at_work};
		do_eval    = 1'b0;
		do_begin   = 1'b0;
		do_finish  = 1'b0;
		fin_status = aps_pkg::ST_OK;
		kind       = aps_pkg::CL_OK;
		steps      = 3'b000;
		reached    = 1'b0;
		err        = aps_pkg::ST_OK;

		phase_n   = phase_q;
		target_n  = target_q;
		pending_n = pending_q;
		timer_n   = timer_q;
		tries_n   = tries_q;
		res_n     = '0;

		// current step is the lowest pending bit
		if (pending_q[0]) cur = aps_pkg::STEP_RETRACT;
		else if (pending_q[1]) cur = aps_pkg::STEP_MOVE;
		else cur = aps_pkg::STEP_ENGAGE;

		case (phase_q)
			aps_pkg::PH_SETTLE: begin
				if (timer_q > 16'd1) timer_n = timer_q - 16'd1;
				else if (tries_q >= TRIES_LIMIT) begin
					do_finish  = 1'b1;
					fin_status = aps_pkg::ST_POS_UNKNOWN;
				end else do_eval = 1'b1;
			end
			aps_pkg::PH_WAIT: begin
				if (cur == aps_pkg::STEP_RETRACT) begin
					reached = cmd_in.weight_home;
					err     = aps_pkg::ST_RETRACT_TIMEOUT;
				end else if (cur == aps_pkg::STEP_MOVE) begin
					reached = target_q ? cmd_in.at_service : cmd_in.at_work;
					err     = aps_pkg::ST_MODULE_TIMEOUT;
				end else begin
					reached = !cmd_in.weight_home;
					err     = aps_pkg::ST_ENGAGE_TIMEOUT;
				end
				if (reached) begin
					pending_n = pending_q & ~cur;
					if (pending_n != 3'b000) do_begin = 1'b1;
					else do_finish = 1'b1;
				end else if (timer_q > 16'd1) timer_n = timer_q - 16'd1;
				else begin
					do_finish  = 1'b1;
					fin_status = err;
				end
			end
			default: begin
				phase_n = aps_pkg::PH_IDLE;
				if (cmd_in.mode == aps_pkg::MODE_WORK || cmd_in.mode == aps_pkg::MODE_SERVICE)
				begin
					target_n = (cmd_in.mode == aps_pkg::MODE_SERVICE);
					tries_n  = 2'd0;
					do_eval  = 1'b1;
				end
			end
		endcase

		// Classify the sampled switch code
		if (do_eval) begin
			classify(cfg.weight_fitted, target_n, code, kind, steps);
			case (kind)
				aps_pkg::CL_SETTLE: begin
					tries_n = tries_n + 2'd1;
					timer_n = cfg.settle_ticks;
					phase_n = aps_pkg::PH_SETTLE;
				end
				aps_pkg::CL_FAULT: begin
					do_finish  = 1'b1;
					fin_status = aps_pkg::ST_SWITCH_FAULT;
				end
				aps_pkg::CL_OK: do_finish = 1'b1;
				default: begin
					pending_n = steps;
					do_begin  = 1'b1;
				end
			endcase
		end

		// Start the lowest pending step: pulse and load its timeout
		if (do_begin) begin
			phase_n = aps_pkg::PH_WAIT;
			if (pending_n[0]) begin
				res_n.pulse_weight_retract = 1'b1;
				timer_n = cfg.weight_timeout;
			end else if (pending_n[1]) begin
				if (target_n) res_n.pulse_to_service = 1'b1;
				else res_n.pulse_to_work = 1'b1;
				timer_n = cfg.module_timeout;
			end else begin
				res_n.pulse_weight_engage = 1'b1;
				timer_n = cfg.weight_timeout;
			end
		end

		// Close the sequence and report status
		if (do_finish) begin
			phase_n      = aps_pkg::PH_IDLE;
			pending_n    = 3'b000;
			timer_n      = 16'd0;
			tries_n      = 2'd0;
			res_n.done_res = 1'b1;
			res_n.status   = fin_status;
		end

		res_n.busy_res = (phase_n != aps_pkg::PH_IDLE);
	end

	// Advance the state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= aps_pkg::PH_IDLE;
			target_q  <= 1'b0;
			pending_q <= 3'b000;
			timer_q   <= 16'd0;
			tries_q   <= 2'd0;
		end else if (take) begin
			phase_q   <= phase_n;
			target_q  <= target_n;
			pending_q <= pending_n;
			timer_q   <= timer_n;
			tries_q   <= tries_n;
		end
	end

endmodule

### hw/rtl/aps_checker.sv
// Port-level checks on the sequencer's result channel, bound to the top level.
// Depends on actuator_position_sequencer and its interface ports.
`timescale 1ns / 1ps

module aps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       p_work,
	input logic       p_service,
	input logic       p_retract,
	input logic       p_engage,
	input logic       busy,
	input logic       done,
	input logic [2:0] status
);

	// a finished sequence leaves the block idle
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done |-> !busy)
		else $error("done_res with busy_res set");

	// status is meaningful only on the finishing transaction
	a_status_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !done |-> status == 3'd0)
		else $error("nonzero status without done_res");

	// at most one command pulse per transaction, and a pulse means a step is running
	a_one_pulse_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (p_work || p_service || p_retract || p_engage)
		|-> $onehot({p_work, p_service, p_retract, p_engage}) && busy && !done)
		else $error("bad pulse combination");

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid
		&& $stable({p_work, p_service, p_retract, p_engage, busy, done, status}))
		else $error("result changed while stalled");

endmodule

bind actuator_position_sequencer aps_checker u_aps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.p_work    (res.pulse_to_work),
	.p_service (res.pulse_to_service),
	.p_retract (res.pulse_weight_retract),
	.p_engage  (res.pulse_weight_engage),
	.busy      (res.busy_res),
	.done      (res.done_res),
	.status    (res.status)
);
